// ----- hdl/reb_pkg.sv -----
// ----------------------------------------------------------------------------
// reb_pkg: shared types and constants for the rotary encoder event core
// Event codes, configuration register map, reset values and the structs
// passed between the configuration block, the tick logic and the top level.
// ----------------------------------------------------------------------------
package reb_pkg;

    localparam int unsigned TimerW = 16;
    localparam int unsigned CountW = 8;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TimerW-1:0] TIMER_MAX = '1;
    localparam logic [CountW-1:0] COUNT_MAX = '1;

    // reset values of the configuration registers
    localparam logic [TimerW-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [TimerW-1:0] CLICK_WINDOW_RESET = 16'd6000;
    localparam logic [TimerW-1:0] HOLD_RESET = 16'd10000;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLICK_WINDOW = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HOLD = 2'd2;

    // encoder phase pairs, A in bit 1
    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_RIGHT       = 3'd1,
        EV_LEFT        = 3'd2,
        EV_PRESS_RIGHT = 3'd3,
        EV_PRESS_LEFT  = 3'd4,
        EV_CLICK       = 3'd5,
        EV_DOUBLE      = 3'd6,
        EV_HOLD        = 3'd7
    } t_event_code;

    typedef struct packed {
        logic [TimerW-1:0] debounce_ticks;
        logic [TimerW-1:0] click_window_ticks;
        logic [TimerW-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic key_level;
    } t_sample;

    typedef struct packed {
        logic        event_fired;
        t_event_code event_code;
        t_event_code current_state;
    } t_result;

    typedef struct packed {
        logic              pressed_now;
        logic              pressed_before;
        logic              turned_while_held;
        logic [TimerW-1:0] debounce_timer;
        logic [CountW-1:0] click_count;
        logic [TimerW-1:0] click_timer;
        logic [TimerW-1:0] hold_timer;
        logic [1:0]        previous_ab;
        t_event_code       state_code;
    } t_state;

    function automatic logic [TimerW-1:0] sat_inc16(input logic [TimerW-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CountW-1:0] sat_inc8(input logic [CountW-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- hdl/reb_in_if.sv -----
// ----------------------------------------------------------------------------
// reb_in_if: sample tick channel
// Valid/ready channel carrying the encoder phases and the raw key level.
// ----------------------------------------------------------------------------
interface reb_in_if;
    logic valid;
    logic ready;
    logic phase_a;
    logic phase_b;
    logic key_level;

    modport source (output valid, output phase_a, output phase_b, output key_level,
                    input ready);
    modport sink (input valid, input phase_a, input phase_b, input key_level,
                  output ready);
endinterface

// ----- hdl/reb_out_if.sv -----
// ----------------------------------------------------------------------------
// reb_out_if: event result channel
// Valid/ready channel carrying one event result per sample tick.
// ----------------------------------------------------------------------------
interface reb_out_if;
    logic       valid;
    logic       ready;
    logic       event_fired;
    logic [2:0] event_code;
    logic [2:0] current_state;

    modport source (output valid, output event_fired, output event_code,
                    output current_state, input ready);
    modport sink (input valid, input event_fired, input event_code,
                  input current_state, output ready);
endinterface

// ----- hdl/reb_cfg.sv -----
// ----------------------------------------------------------------------------
// reb_cfg: configuration registers
// Holds debounce, click window and hold thresholds; writes to unused
// indexes are dropped.
// ----------------------------------------------------------------------------
module reb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [reb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [reb_pkg::TimerW-1:0]  i_cfg_data,
    output reb_pkg::t_cfg               o_cfg
);

    reb_pkg::t_cfg r_cfg;
    reb_pkg::t_cfg n_cfg;

    // decode the register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                reb_pkg::CFG_DEBOUNCE:     n_cfg.debounce_ticks = i_cfg_data;
                reb_pkg::CFG_CLICK_WINDOW: n_cfg.click_window_ticks = i_cfg_data;
                reb_pkg::CFG_HOLD:         n_cfg.hold_ticks = i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= reb_pkg::DEBOUNCE_RESET;
            r_cfg.click_window_ticks <= reb_pkg::CLICK_WINDOW_RESET;
            r_cfg.hold_ticks         <= reb_pkg::HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/reb_step.sv -----
// ----------------------------------------------------------------------------
// reb_step: per-tick event logic
// Keeps the debounce, click and hold state and works out the event for the
// sample held in the input register; state advances when the result moves on.
// ----------------------------------------------------------------------------
module reb_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  reb_pkg::t_sample i_smp,
    input  reb_pkg::t_cfg    i_cfg,
    output reb_pkg::t_result o_res
);

    reb_pkg::t_state r_st;
    reb_pkg::t_state n_st;

    logic                       w_key_down;
    logic [1:0]                 w_ab;
    logic [reb_pkg::TimerW-1:0] w_dt;
    logic                       w_released;
    logic                       w_holding;
    logic [reb_pkg::TimerW-1:0] w_ct;
    logic [reb_pkg::CountW-1:0] w_clicks;
    logic                       w_fired;
    reb_pkg::t_event_code       w_code;

    // debounce, click counting, hold timing and event selection for one tick
    always_comb begin
        n_st       = r_st;
        w_key_down = ~i_smp.key_level;
        w_ab       = {i_smp.phase_a, i_smp.phase_b};
        w_fired    = 1'b0;
        w_code     = reb_pkg::EV_NONE;

        // debounce: timer runs on once started
        w_dt = r_st.debounce_timer;
        if (w_dt != '0) begin
            w_dt = reb_pkg::sat_inc16(w_dt);
        end
        if (w_key_down != r_st.pressed_before) begin
            if (w_dt >= i_cfg.debounce_ticks) begin
                w_dt = '0;
                n_st.pressed_now = w_key_down;
            end else if (w_dt == '0) begin
                w_dt = reb_pkg::TimerW'(1);
            end
        end
        n_st.debounce_timer = w_dt;

        // click counting
        w_released = r_st.pressed_before & ~n_st.pressed_now;
        w_ct = r_st.click_timer;
        if (w_released) begin
            if (r_st.click_timer < i_cfg.click_window_ticks) begin
                if (!r_st.turned_while_held) begin
                    n_st.click_count = reb_pkg::sat_inc8(r_st.click_count);
                end else begin
                    n_st.turned_while_held = 1'b0;
                    n_st.click_count = '0;
                end
            end else begin
                n_st.click_count = reb_pkg::CountW'(1);
            end
            w_ct = '0;
        end else if (r_st.click_timer >= i_cfg.click_window_ticks) begin
            n_st.click_count = '0;
        end
        n_st.click_timer = (n_st.click_count == '0) ? '0 : reb_pkg::sat_inc16(w_ct);

        // hold timing: zero means not holding
        w_holding = r_st.pressed_before & n_st.pressed_now;
        n_st.hold_timer = w_holding ? reb_pkg::sat_inc16(r_st.hold_timer) : '0;

        // event selection
        w_clicks = (n_st.click_count != '0 && n_st.click_timer >= i_cfg.click_window_ticks)
                   ? n_st.click_count : '0;
        if (r_st.previous_ab == reb_pkg::AB_00 && w_ab == reb_pkg::AB_01) begin
            w_fired = 1'b1;
            if (w_holding) begin
                w_code = reb_pkg::EV_PRESS_RIGHT;
                n_st.turned_while_held = 1'b1;
            end else begin
                w_code = reb_pkg::EV_RIGHT;
            end
        end else if (r_st.previous_ab == reb_pkg::AB_01 && w_ab == reb_pkg::AB_00) begin
            w_fired = 1'b1;
            if (w_holding) begin
                w_code = reb_pkg::EV_PRESS_LEFT;
                n_st.turned_while_held = 1'b1;
            end else begin
                w_code = reb_pkg::EV_LEFT;
            end
        end else if (n_st.turned_while_held) begin
            n_st.state_code = reb_pkg::EV_NONE;
        end else if (w_clicks == '0) begin
            if (n_st.hold_timer != '0 &&
                (n_st.hold_timer - 1'b1) >= i_cfg.hold_ticks) begin
                w_code  = reb_pkg::EV_HOLD;
                w_fired = 1'b1;
            end
        end else if (w_clicks == reb_pkg::CountW'(1)) begin
            w_code  = reb_pkg::EV_CLICK;
            w_fired = 1'b1;
        end else if (w_clicks == reb_pkg::CountW'(2)) begin
            w_code  = reb_pkg::EV_DOUBLE;
            w_fired = 1'b1;
        end else begin
            // three or more clicks: no event, state set to none
            n_st.state_code = reb_pkg::EV_NONE;
        end
        if (w_fired) begin
            n_st.state_code = w_code;
        end

        n_st.previous_ab    = w_ab;
        n_st.pressed_before = n_st.pressed_now;
    end

    // advance the state when the tick's result is taken into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_res.event_fired   = w_fired;
    assign o_res.event_code    = w_code;
    assign o_res.current_state = n_st.state_code;

endmodule

// ----- hdl/rotary_encoder_button_events_core.sv -----
// ----------------------------------------------------------------------------
// rotary_encoder_button_events_core: encoder turn and key click decoder
// Turns sample ticks of encoder phases and key level into turn, click,
// double click and hold events, one result per tick.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  i_in_ch   | in  | valid/ready   | phase_a, phase_b, key_level
//  o_out_ch  | out | valid/ready   | event_fired, event_code, current_state
//  cfg       | in  | write enable  | i_cfg_idx, i_cfg_data (16 bit)
//
//  One tick per cycle sustained while the output is not stalled; a tick passes
//  through the input register, then the result register, before its result is valid.
//  Input ready is high while the input register is empty or moving on, so it
//  follows output ready combinationally when both registers are full.
//  A stalled result holds in the result register; the next tick waits in the
//  input register, and the tick after that is refused until space frees.
//  Synchronous active-low reset clears both registers, the event state and
//  loads the default thresholds.
// ----------------------------------------------------------------------------
module rotary_encoder_button_events_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    reb_in_if.sink                      i_in_ch,
    reb_out_if.source                   o_out_ch,
    input  logic                        i_cfg_we,
    input  logic [reb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [reb_pkg::TimerW-1:0]  i_cfg_data
);

    reb_pkg::t_cfg    w_cfg;
    reb_pkg::t_result w_res;

    logic             r_in_vld;
    reb_pkg::t_sample r_in_smp;
    logic             r_out_vld;
    reb_pkg::t_result r_out_res;

    logic w_adv;
    logic w_in_take;

    reb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    reb_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_smp   (r_in_smp),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // advance when the result register is empty or being drained
    assign w_adv            = r_in_vld & (~r_out_vld | o_out_ch.ready);
    assign i_in_ch.ready    = ~r_in_vld | w_adv;
    assign w_in_take        = i_in_ch.valid & i_in_ch.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_smp <= '{phase_a: i_in_ch.phase_a, phase_b: i_in_ch.phase_b,
                          key_level: i_in_ch.key_level};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_ch.valid         = r_out_vld;
    assign o_out_ch.event_fired   = r_out_res.event_fired;
    assign o_out_ch.event_code    = r_out_res.event_code;
    assign o_out_ch.current_state = r_out_res.current_state;

    // a code is present exactly when an event fired
    a_fired_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_res.event_fired == (r_out_res.event_code != reb_pkg::EV_NONE)))
        else $error("event_fired and event_code disagree");

    // a fired event becomes the kept state
    a_fired_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_res.event_fired) |->
        (r_out_res.current_state == r_out_res.event_code))
        else $error("current_state does not follow fired event");

    // a tick blocked behind a stalled result stays put
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_out_ch.ready) |=> (r_in_vld && $stable(r_in_smp)))
        else $error("input register lost a blocked tick");

    // input refused only while both registers are full
    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ch.ready |-> (r_in_vld && r_out_vld))
        else $error("input refused with free space");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rotary encoder event core
// Feeds sample ticks of encoder phases and key level through the input
// channel, predicts every result tick with a behavioral decoder kept in the
// bench, and compares each result transfer field by field. The run walks
// through several register settings, from zero windows to full-scale
// thresholds, under different sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import reb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned GESTURE_CAP = 24;
    localparam logic [1:0] GRAY_SEQ [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [TimerW-1:0]   cfg_data;

    reb_in_if  in_ch ();
    reb_out_if out_ch ();

    rotary_encoder_button_events_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // stimulus and expected results
    t_sample     pending_ticks [$];
    t_result     expected_results [$];
    t_sample     drive_tick;
    t_result     want;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches = 0;
    int unsigned ticks_checked = 0;
    int unsigned settings_written = 0;
    int unsigned cycle_count = 0;
    int unsigned events_seen [8];

    // decoder state and thresholds as the bench sees them
    t_cfg              m_cfg;
    logic              m_pressed_now;
    logic              m_pressed_before;
    logic              m_turned_held;
    logic [TimerW-1:0] m_debounce;
    logic [CountW-1:0] m_clicks;
    logic [TimerW-1:0] m_click_timer;
    logic [TimerW-1:0] m_hold_timer;
    logic [1:0]        m_prev_ab;
    t_event_code       m_state;

    // gesture generator position
    int   enc_pos;
    logic key_lvl;

    always #4 i_clk = ~i_clk;

    function automatic logic [TimerW-1:0] timer_up(input logic [TimerW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic clear_decoder_state();
        m_cfg.debounce_ticks = DEBOUNCE_RESET;
        m_cfg.click_window_ticks = CLICK_WINDOW_RESET;
        m_cfg.hold_ticks = HOLD_RESET;
        m_pressed_now = 1'b0;
        m_pressed_before = 1'b0;
        m_turned_held = 1'b0;
        m_debounce = '0;
        m_clicks = '0;
        m_click_timer = '0;
        m_hold_timer = '0;
        m_prev_ab = AB_00;
        m_state = EV_NONE;
    endtask

    // Advance the decoder by one sample tick and return the result it raises.
    function automatic t_result predict_tick(input t_sample s);
        logic [1:0]        ab;
        logic              key_down;
        logic              released;
        logic              holding;
        logic              fired;
        t_event_code       code;
        logic [CountW-1:0] clicks;
        t_result           r;
        ab = {s.phase_a, s.phase_b};
        key_down = ~s.key_level;
        fired = 1'b0;
        code = EV_NONE;

        // debounce: the timer runs on once started, even if the level returns
        if (m_debounce != 0)
            m_debounce = timer_up(m_debounce);
        if (key_down != m_pressed_before) begin
            if (m_debounce >= m_cfg.debounce_ticks) begin
                m_debounce = '0;
                m_pressed_now = key_down;
            end else if (m_debounce == 0) begin
                m_debounce = TimerW'(1);
            end
        end

        // count releases inside the click window
        released = m_pressed_before && !m_pressed_now;
        if (released) begin
            if (m_click_timer < m_cfg.click_window_ticks) begin
                if (!m_turned_held) begin
                    if (m_clicks != COUNT_MAX)
                        m_clicks = m_clicks + 1'b1;
                end else begin
                    m_turned_held = 1'b0;
                    m_clicks = '0;
                end
            end else begin
                m_clicks = CountW'(1);
            end
            m_click_timer = '0;
        end else if (m_click_timer >= m_cfg.click_window_ticks) begin
            m_clicks = '0;
        end
        if (m_clicks == 0)
            m_click_timer = '0;
        else
            m_click_timer = timer_up(m_click_timer);

        // time a continuous hold
        holding = m_pressed_before && m_pressed_now;
        if (holding)
            m_hold_timer = (m_hold_timer == 0) ? TimerW'(1) : timer_up(m_hold_timer);
        else
            m_hold_timer = '0;

        // pick the event: turns first, then the held-turn lockout, then clicks or hold
        if (m_prev_ab == AB_00 && ab == AB_01) begin
            code = holding ? EV_PRESS_RIGHT : EV_RIGHT;
            if (holding)
                m_turned_held = 1'b1;
            fired = 1'b1;
        end else if (m_prev_ab == AB_01 && ab == AB_00) begin
            code = holding ? EV_PRESS_LEFT : EV_LEFT;
            if (holding)
                m_turned_held = 1'b1;
            fired = 1'b1;
        end else if (m_turned_held) begin
            m_state = EV_NONE;
        end else begin
            clicks = (m_clicks != 0 && m_click_timer >= m_cfg.click_window_ticks) ?
                     m_clicks : '0;
            if (clicks == 0) begin
                if (m_hold_timer != 0 && m_hold_timer - 1'b1 >= m_cfg.hold_ticks) begin
                    code = EV_HOLD;
                    fired = 1'b1;
                end
            end else if (clicks == 1) begin
                code = EV_CLICK;
                fired = 1'b1;
            end else if (clicks == 2) begin
                code = EV_DOUBLE;
                fired = 1'b1;
            end else begin
                m_state = EV_NONE;
            end
        end
        if (fired)
            m_state = code;

        m_prev_ab = ab;
        m_pressed_before = m_pressed_now;

        r.event_fired = fired;
        r.event_code = code;
        r.current_state = m_state;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int want_v, input int got_v);
        $display("[%0t] result %0d %s: expected %0d, got %0d",
                 $time, ticks_checked, field, want_v, got_v);
        mismatches++;
    endtask

    task automatic push_run(input logic a, input logic b, input logic key, input int n);
        t_sample s;
        s.phase_a = a;
        s.phase_b = b;
        s.key_level = key;
        repeat (n) pending_ticks.push_back(s);
    endtask

    task automatic push_encoder(input int n);
        push_run(GRAY_SEQ[enc_pos][1], GRAY_SEQ[enc_pos][0], key_lvl, n);
    endtask

    task automatic nudge_encoder();
        enc_pos = (enc_pos + ($urandom_range(1) ? 1 : 3)) % 4;
    endtask

    // Queue random gestures sized to the current thresholds: press/release
    // pairs with turns mixed in, detent walks, short bounces and raw noise.
    task automatic queue_gestures(input int n_ticks);
        int added;
        int kind;
        int len;
        int cap_press;
        int cap_release;
        int cap_bounce;
        added = 0;
        cap_press = int'(m_cfg.debounce_ticks) + int'(m_cfg.hold_ticks) + 4;
        cap_press = (cap_press > GESTURE_CAP) ? GESTURE_CAP : cap_press;
        cap_release = int'(m_cfg.debounce_ticks) + 2 * int'(m_cfg.click_window_ticks) + 2;
        cap_release = (cap_release > GESTURE_CAP) ? GESTURE_CAP : cap_release;
        cap_bounce = int'(m_cfg.debounce_ticks) + 1;
        cap_bounce = (cap_bounce > 20) ? 20 : cap_bounce;
        while (added < n_ticks) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                key_lvl = 1'b0;
                len = $urandom_range(cap_press);
                repeat (len) begin
                    if ($urandom_range(9) == 0)
                        nudge_encoder();
                    push_encoder(1);
                end
                added += len;
                key_lvl = 1'b1;
                len = $urandom_range(cap_release);
                repeat (len) begin
                    if ($urandom_range(19) == 0)
                        nudge_encoder();
                    push_encoder(1);
                end
                added += len;
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    nudge_encoder();
                    len = $urandom_range(1, 3);
                    push_encoder(len);
                    added += len;
                end
            end else if (kind < 88) begin
                len = $urandom_range(1, cap_bounce);
                key_lvl = ~key_lvl;
                push_encoder(len);
                key_lvl = ~key_lvl;
                push_encoder(1);
                added += len + 1;
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) push_run(1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)), 1);
                added += len;
            end
        end
    endtask

    // Wait until no tick is queued, in flight or owed, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_settings(input int db, input int win, input int hold);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_DEBOUNCE;
        cfg_data <= TimerW'(db);
        @(posedge i_clk);
        cfg_idx <= CFG_CLICK_WINDOW;
        cfg_data <= TimerW'(win);
        @(posedge i_clk);
        cfg_idx <= CFG_HOLD;
        cfg_data <= TimerW'(hold);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        m_cfg.debounce_ticks = TimerW'(db);
        m_cfg.click_window_ticks = TimerW'(win);
        m_cfg.hold_ticks = TimerW'(hold);
        settings_written++;
    endtask

    // Driver: predict each transfer as it happens, then offer the next tick.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_tick(
                    t_sample'({in_ch.phase_a, in_ch.phase_b, in_ch.key_level})));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_tick = pending_ticks.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.phase_a <= drive_tick.phase_a;
                    in_ch.phase_b <= drive_tick.phase_b;
                    in_ch.key_level <= drive_tick.key_level;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check every result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                ticks_checked++;
                if (out_ch.event_fired === 1'b1)
                    events_seen[out_ch.event_code]++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, out_ch.event_code);
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.event_fired !== want.event_fired)
                        report_mismatch("event_fired", want.event_fired, out_ch.event_fired);
                    if (out_ch.event_code !== want.event_code)
                        report_mismatch("event_code", want.event_code, out_ch.event_code);
                    if (out_ch.current_state !== want.current_state)
                        report_mismatch("current_state", want.current_state,
                                        out_ch.current_state);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        clear_decoder_state();
        enc_pos = 0;
        key_lvl = 1'b1;
        cfg_we = 1'b0;
        cfg_idx = CFG_DEBOUNCE;
        cfg_data = '0;
        i_rst_n = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 55;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: only turns and noise can show in a short run
        queue_gestures(40);
        drain();

        // zero windows: plain turns, instant press, hold, click, held turns
        write_settings(0, 0, 0);
        push_run(0, 0, 1, 1);
        push_run(0, 1, 1, 1);
        push_run(0, 0, 1, 1);
        push_run(1, 1, 1, 1);
        push_run(1, 0, 1, 1);
        push_run(0, 0, 1, 1);
        push_run(0, 0, 0, 2);
        push_run(0, 0, 1, 2);
        push_run(0, 0, 0, 2);
        push_run(0, 1, 0, 2);
        push_run(0, 0, 0, 1);
        push_run(0, 0, 1, 1);
        push_run(1, 1, 1, 1);
        enc_pos = 2;
        queue_gestures(60);
        drain();

        // debounce run-on: brief press, level returns, timer keeps counting
        write_settings(3, 12, 20);
        enc_pos = 0;
        push_run(0, 0, 0, 1);
        push_run(0, 0, 1, 3);
        push_run(0, 0, 0, 2);
        key_lvl = 1'b0;
        queue_gestures(60);
        drain();

        // swap the stall pattern
        send_idle_pct = 55;
        recv_idle_pct = 27;
        write_settings(1, 5, 8);
        queue_gestures(60);
        drain();

        write_settings($urandom_range(4), $urandom_range(1, 30), $urandom_range(40));
        queue_gestures(60);
        drain();

        // full-scale thresholds, no stalls: clicks pile up inside the open
        // window, a long press never reaches hold
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings(0, 16'hFFFF, 16'hFFFF);
        repeat (4) begin
            push_run(0, 0, 0, 1);
            push_run(0, 0, 1, 1);
        end
        push_run(0, 0, 0, 12);
        push_run(0, 0, 1, 6);
        drain();

        $display("checked %0d result ticks across %0d register settings",
                 ticks_checked, settings_written);
        $display("events: right %0d left %0d held-right %0d held-left %0d",
                 events_seen[EV_RIGHT], events_seen[EV_LEFT], events_seen[EV_PRESS_RIGHT],
                 events_seen[EV_PRESS_LEFT]);
        $display("events: click %0d double %0d hold %0d",
                 events_seen[EV_CLICK], events_seen[EV_DOUBLE], events_seen[EV_HOLD]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/reb_pkg.sv
hdl/reb_in_if.sv
hdl/reb_out_if.sv
hdl/reb_cfg.sv
hdl/reb_step.sv
hdl/rotary_encoder_button_events_core.sv
tb/sv/tb.sv
